// File: src/scancode_to_ascii_translator_assert.svh
// Assertion macros for the scancode translator.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_ASSERT_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCTA_ASSERT_COMB(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/scta_pkg.sv
// Shared types, scancode constants and key tables for the scancode translator.
// No dependencies.
`default_nettype none

package scta_pkg;

  localparam int unsigned KeyCount = 84;

  // Modifier scancodes (make and break)
  localparam logic [7:0] ShiftLeftMake   = 8'h2A;
  localparam logic [7:0] ShiftRightMake  = 8'h36;
  localparam logic [7:0] CtrlMake        = 8'h1D;
  localparam logic [7:0] AltMake         = 8'h38;
  localparam logic [7:0] CapsMake        = 8'h3A;
  localparam logic [7:0] ShiftLeftBreak  = 8'hAA;
  localparam logic [7:0] ShiftRightBreak = 8'hB6;
  localparam logic [7:0] CtrlBreak       = 8'h9D;
  localparam logic [7:0] AltBreak        = 8'hB8;

  localparam logic [6:0] AsciiLowerA = 7'h61;
  localparam logic [6:0] AsciiLowerZ = 7'h7A;
  localparam logic [6:0] CaseOffset  = 7'h20;

  typedef struct packed {
    logic caps;
    logic alt;
    logic ctrl;
    logic shift;
  } mod_flags_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
  } char_res_t;

  // Normal key table; empty entries give zero
  function automatic logic [6:0] key_plain(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h01: c = 7'h1B; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
      7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
      7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A; 7'h1E: c = 7'h61; 7'h1F: c = 7'h73;
      7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
      7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C; 7'h27: c = 7'h3B;
      7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C; 7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
      7'h47: c = 7'h37; 7'h48: c = 7'h38; 7'h49: c = 7'h39; 7'h4A: c = 7'h2D;
      7'h4B: c = 7'h34; 7'h4C: c = 7'h35; 7'h4D: c = 7'h36; 7'h4E: c = 7'h2B;
      7'h4F: c = 7'h31; 7'h50: c = 7'h32; 7'h51: c = 7'h33; 7'h52: c = 7'h30;
      7'h53: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted key table: letters uppercase, symbol keys remapped, rest as normal
  function automatic logic [6:0] key_shifted(input logic [6:0] code);
    logic [6:0] p;
    logic [6:0] c;
    p = key_plain(code);
    case (code)
      7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
      7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
      7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
      7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D; 7'h27: c = 7'h3A; 7'h28: c = 7'h22;
      7'h29: c = 7'h7E; 7'h2B: c = 7'h7C; 7'h33: c = 7'h3C; 7'h34: c = 7'h3E;
      7'h35: c = 7'h3F;
      default: begin
        if (p >= AsciiLowerA && p <= AsciiLowerZ) begin
          c = p - CaseOffset;
        end else begin
          c = p;
        end
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/scancode_to_ascii_translator.sv
// Top level of the set-1 scancode to ASCII translator.
// Depends on scta_pkg, scta_decode and scancode_to_ascii_translator_assert.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in_     | input     | in_valid/in_stall  | in_scan_byte[7:0]
//   out_    | output    | out_valid/out_stall| out_char_valid, out_char_code[6:0],
//           |           |                    | out_shift/ctrl/alt_held, out_caps_on
//
// One request per clock sustained while out_stall is low; each request passes the input
// register, then is decoded into the result register. Modifier flags update as a
// request moves into the result register. Synchronous active-low reset clears both stage
// valids and all flags. out_stall holds the result and, once the input
// register is full, backs up into in_stall in the same cycle.
`default_nettype none

module scancode_to_ascii_translator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_scan_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_char_valid,
  output logic [6:0]      out_char_code,
  output logic            out_shift_held,
  output logic            out_ctrl_held,
  output logic            out_alt_held,
  output logic            out_caps_on
);

  `include "scancode_to_ascii_translator_assert.svh"

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  scta_pkg::char_res_t  res_r;
  scta_pkg::char_res_t  res_nxt;
  scta_pkg::mod_flags_t flags_r;
  scta_pkg::mod_flags_t flags_nxt;
  logic                 out_ready;
  logic                 adv;
  logic                 in_acc;

  // Handshake: advance when the result register is free or being taken
  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  scta_decode u_decode (
    .scan_byte (s1_byte_r),
    .flags     (flags_r),
    .flags_nxt (flags_nxt),
    .res       (res_nxt)
  );

  // Control state and modifier flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        flags_r <= flags_nxt;
      end
    end
  end

  // Payload registers: capture input, load result on advance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_scan_byte;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = res_r.char_valid;
  assign out_char_code  = res_r.char_code;
  assign out_shift_held = flags_r.shift;
  assign out_ctrl_held  = flags_r.ctrl;
  assign out_alt_held   = flags_r.alt;
  assign out_caps_on    = flags_r.caps;

  // Checks
  `SCTA_ASSERT_COMB(a_valid_code, out_valid_r, out_char_valid == (out_char_code != 7'h00), "char_valid disagrees with char_code")
  `SCTA_ASSERT_NEXT(a_flags_hold, rst_n && !adv, $stable(flags_r), "modifier flags changed without an advancing request")
  `SCTA_ASSERT_NEXT(a_break_no_char, rst_n && adv && s1_byte_r[7], !out_char_valid, "break code produced a character")

endmodule

`default_nettype wire

// File: src/scta_decode.sv
// Combinational decode of one scancode: modifier update and key lookup.
// Depends on scta_pkg.
`default_nettype none

module scta_decode (
  input  wire logic [7:0]          scan_byte,
  input  wire scta_pkg::mod_flags_t flags,
  output scta_pkg::mod_flags_t     flags_nxt,
  output scta_pkg::char_res_t      res
);

  logic       is_mod;
  logic [6:0] key_idx;
  logic [6:0] plain_c;
  logic [6:0] ch;

  // Apply modifier make and break codes
  always_comb begin
    flags_nxt = flags;
    is_mod    = 1'b1;
    case (scan_byte)
      scta_pkg::ShiftLeftMake,
      scta_pkg::ShiftRightMake:  flags_nxt.shift = 1'b1;
      scta_pkg::CtrlMake:        flags_nxt.ctrl  = 1'b1;
      scta_pkg::AltMake:         flags_nxt.alt   = 1'b1;
      scta_pkg::CapsMake:        flags_nxt.caps  = ~flags.caps;
      scta_pkg::ShiftLeftBreak,
      scta_pkg::ShiftRightBreak: flags_nxt.shift = 1'b0;
      scta_pkg::CtrlBreak:       flags_nxt.ctrl  = 1'b0;
      scta_pkg::AltBreak:        flags_nxt.alt   = 1'b0;
      default:                   is_mod          = 1'b0;
    endcase
  end

  // Look up make codes; modifiers and breaks give no character
  always_comb begin
    key_idx = scan_byte[6:0];
    plain_c = scta_pkg::key_plain(key_idx);
    ch      = 7'h00;
    if (!is_mod && !scan_byte[7] && ({25'd0, key_idx} < scta_pkg::KeyCount)) begin
      if (flags.shift) begin
        ch = scta_pkg::key_shifted(key_idx);
      end else if (flags.caps && plain_c >= scta_pkg::AsciiLowerA &&
                   plain_c <= scta_pkg::AsciiLowerZ) begin
        ch = plain_c - scta_pkg::CaseOffset;
      end else begin
        ch = plain_c;
      end
    end
    res.char_valid = (ch != 7'h00);
    res.char_code  = ch;
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the set-1 scancode to ASCII translator.
// Holds its own key tables and modifier tracking; depends on scta_pkg and the RTL only.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DirRows       = 26;
  localparam int          RandPerPhase  = 608;
  localparam int          WatchdogLimit = 5000;
  localparam int          DrainCycles   = 8;
  localparam int          LongHoldLen   = 60;
  localparam int          LongHoldAt    = 1500;
  localparam logic [7:0]  CapsBreak     = 8'hBA;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
  } key_result_t;

  // Key tables, entry 0 first
  localparam logic [0:scta_pkg::KeyCount-1][7:0] PlainKeys = {
    64'h001B313233343536, 64'h373839302D3D0809,
    64'h7177657274797569, 64'h6F705B5D0A006173,
    64'h646667686A6B6C3B, 64'h2760005C7A786376,
    64'h626E6D2C2E2F002A, 64'h0020000000000000,
    64'h0000000000000037, 64'h38392D3435362B31,
    32'h3233302E
  };

  localparam logic [0:scta_pkg::KeyCount-1][7:0] ShiftedKeys = {
    64'h001B21402324255E, 64'h262A28295F2B0809,
    64'h5157455254595549, 64'h4F507B7D0A004153,
    64'h444647484A4B4C3A, 64'h227E007C5A584356,
    64'h424E4D3C3E3F002A, 64'h0020000000000000,
    64'h0000000000000037, 64'h38392D3435362B31,
    32'h3233302E
  };

  // Directed rows: scan byte, typed flag, then char_valid, char_code and
  // the flags shift ctrl alt caps; untyped rows go through the predictor
  localparam logic [0:DirRows-1][20:0] DirTable = {
    {8'h00, 1'b1, 1'b0, 7'h00, 4'b0000},  // empty entry right after reset
    {8'hFF, 1'b1, 1'b0, 7'h00, 4'b0000},  // top break code
    {8'h1E, 1'b0, 12'h000},               // plain letter
    {8'h3A, 1'b1, 1'b0, 7'h00, 4'b0001},  // caps lock on
    {8'hBA, 1'b0, 12'h000},               // caps lock break changes nothing
    {8'h1E, 1'b0, 12'h000},               // letter under caps lock
    {8'h02, 1'b0, 12'h000},               // digit under caps lock keeps normal table
    {8'h2A, 1'b0, 12'h000},               // left shift make
    {8'h02, 1'b0, 12'h000},               // shifted digit
    {8'h1E, 1'b0, 12'h000},               // shift wins over caps lock
    {8'h3A, 1'b0, 12'h000},               // caps lock off while shifted
    {8'h36, 1'b0, 12'h000},               // right shift make while held
    {8'hAA, 1'b0, 12'h000},               // left shift break
    {8'h36, 1'b0, 12'h000},
    {8'hB6, 1'b0, 12'h000},               // right shift break
    {8'h1D, 1'b0, 12'h000},               // ctrl make
    {8'h2E, 1'b0, 12'h000},               // ctrl leaves the character alone
    {8'h38, 1'b0, 12'h000},               // alt make
    {8'h58, 1'b1, 1'b0, 7'h00, 4'b0110},  // F12, no character
    {8'h59, 1'b1, 1'b0, 7'h00, 4'b0110},  // code past the table
    {8'h9D, 1'b0, 12'h000},               // ctrl break
    {8'hB8, 1'b0, 12'h000},               // alt break
    {8'h53, 1'b1, 1'b1, 7'h2E, 4'b0000},  // last table entry
    {8'h7F, 1'b1, 1'b0, 7'h00, 4'b0000},  // top make code
    {8'hE0, 1'b1, 1'b0, 7'h00, 4'b0000},  // extended prefix
    {8'h80, 1'b1, 1'b0, 7'h00, 4'b0000}   // lowest break code
  };

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_scan_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic       out_char_valid;
  logic [6:0] out_char_code;
  logic       out_shift_held;
  logic       out_ctrl_held;
  logic       out_alt_held;
  logic       out_caps_on;

  scta_pkg::mod_flags_t key_flags = '0;
  key_result_t pending_keys[$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  bit          long_hold_done = 1'b0;
  int          mismatches     = 0;
  int          results_seen   = 0;
  int          chars_seen     = 0;
  int          idle_cycles    = 0;

  scancode_to_ascii_translator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_valid (out_char_valid),
    .out_char_code  (out_char_code),
    .out_shift_held (out_shift_held),
    .out_ctrl_held  (out_ctrl_held),
    .out_alt_held   (out_alt_held),
    .out_caps_on    (out_caps_on)
  );

  always #5 clk = ~clk;

  // Update the modifier flags and look up the character for one scancode
  function automatic key_result_t translate_scan(input logic [7:0] code);
    key_result_t res;
    logic [6:0]  ch;
    ch = 7'h00;
    case (code)
      scta_pkg::ShiftLeftMake, scta_pkg::ShiftRightMake:   key_flags.shift = 1'b1;
      scta_pkg::CtrlMake:                                  key_flags.ctrl  = 1'b1;
      scta_pkg::AltMake:                                   key_flags.alt   = 1'b1;
      scta_pkg::CapsMake:                    key_flags.caps  = ~key_flags.caps;
      scta_pkg::ShiftLeftBreak, scta_pkg::ShiftRightBreak: key_flags.shift = 1'b0;
      scta_pkg::CtrlBreak:                                 key_flags.ctrl  = 1'b0;
      scta_pkg::AltBreak:                                  key_flags.alt   = 1'b0;
      default: begin
        if (!code[7] && code < scta_pkg::KeyCount) begin
          if (key_flags.shift) begin
            ch = ShiftedKeys[code[6:0]][6:0];
          end else begin
            ch = PlainKeys[code[6:0]][6:0];
            if (key_flags.caps && ch >= scta_pkg::AsciiLowerA &&
                ch <= scta_pkg::AsciiLowerZ) begin
              ch = ch - scta_pkg::CaseOffset;
            end
          end
        end
      end
    endcase
    res.char_valid = (ch != 7'h00);
    res.char_code  = ch;
    res.shift_held = key_flags.shift;
    res.ctrl_held  = key_flags.ctrl;
    res.alt_held   = key_flags.alt;
    res.caps_on    = key_flags.caps;
    return res;
  endfunction

  // Mix modifiers, table keys, empty keys and breaks
  function automatic logic [7:0] pick_scan_code();
    int r;
    logic [7:0] code;
    r = $urandom_range(99);
    if (r < 15) begin
      case ($urandom_range(9))
        0:       code = scta_pkg::ShiftLeftMake;
        1:       code = scta_pkg::ShiftRightMake;
        2:       code = scta_pkg::CtrlMake;
        3:       code = scta_pkg::AltMake;
        4:       code = scta_pkg::CapsMake;
        5:       code = scta_pkg::ShiftLeftBreak;
        6:       code = scta_pkg::ShiftRightBreak;
        7:       code = scta_pkg::CtrlBreak;
        8:       code = scta_pkg::AltBreak;
        default: code = CapsBreak;
      endcase
    end else if (r < 70) begin
      code = 8'($urandom_range(8'h53, 8'h00));
    end else if (r < 80) begin
      code = 8'($urandom_range(8'h7F, 8'h54));
    end else begin
      code = 8'($urandom_range(8'hFF, 8'h80));
    end
    return code;
  endfunction

  // Offer one request, wait for acceptance, queue what it should produce
  task automatic send_scan(input logic [7:0] code, input bit typed,
                           input key_result_t typed_res);
    key_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_byte <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = translate_scan(code);
    pending_keys.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and hold off until every result is back
  task automatic drain_pending();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_keys.size() != 0);
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Receiver: stall pattern, one long hold-off, result check
  always @(posedge clk) begin
    key_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (out_char_valid) chars_seen <= chars_seen + 1;
        if (pending_keys.size() == 0) begin
          $error("result with no request outstanding: code 0x%0h", out_char_code);
          mismatches++;
        end else begin
          want = pending_keys.pop_front();
          report_field("char_valid", want.char_valid, out_char_valid);
          report_field("char_code", want.char_code, out_char_code);
          report_field("shift_held", want.shift_held, out_shift_held);
          report_field("ctrl_held", want.ctrl_held, out_ctrl_held);
          report_field("alt_held", want.alt_held, out_alt_held);
          report_field("caps_on", want.caps_on, out_caps_on);
        end
      end
      if (!long_hold_done && results_seen >= LongHoldAt) begin
        long_hold_done <= 1'b1;
        hold_left      <= LongHoldLen;
        out_stall      <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with steady flow on both sides
    for (int i = 0; i < DirRows; i++) begin
      send_scan(DirTable[i][20:13], DirTable[i][12], key_result_t'(DirTable[i][11:0]));
    end
    drain_pending();

    // Random traffic under three idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 34;
          recv_stall_pct <= 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct <= 34;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        send_scan(pick_scan_code(), 1'b0, '0);
      end
      drain_pending();
    end

    // Let stray results show up before closing
    repeat (DrainCycles) @(posedge clk);
    if (pending_keys.size() != 0) begin
      $error("%0d results never arrived", pending_keys.size());
      mismatches++;
    end

    $display("Checked %0d translated scancodes, %0d of them characters,", results_seen,
             chars_seen);
    $display("under three idle mixes, a long output hold-off and a full drain per phase.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
